[rtl/assert_macros.svh]
// Assertion macros shared by the deframer RTL modules.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/cpd_pkg.sv]
// Types, constants and the CRC-16 byte update for the packet deframer.
// No dependencies; imported by every deframer module.
package cpd_pkg;

   localparam int DATA_W    = 8;
   localparam int CRC_W     = 16;
   localparam int POS_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // header byte accepted
      logic collect;   // packet byte accepted
      logic load_out;  // load the output register from the packet store
      logic advance;   // step to the next byte to emit
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hdr_match;  // incoming byte equals the header byte
      logic cnt_last;   // the next byte collected completes the packet
      logic crc_match;  // checksum in the last two bytes matches the CRC
      logic emit_last;  // the output register holds the final packet byte
   } status_type;

   // Reflected CRC-16 update over one byte, least significant bit first.
   function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                     input logic [DATA_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
      for (int i = 0; i < DATA_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/cpd_ctrl.sv]
// Controller state machine of the packet deframer: hunt, collect, emit.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_ctrl
   import cpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {ST_HUNT, ST_COLLECT, ST_EMIT, ST_WAIT} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_acc, rsp_acc;

   assign req_stall = !(state_ff == ST_HUNT || state_ff == ST_COLLECT);
   assign rsp_valid = rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         ST_HUNT: begin
            if (req_acc && status.hdr_match) begin
               cmd.start = 1'b1;
               state_in  = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (req_acc) begin
               cmd.collect = 1'b1;
               if (status.cnt_last) begin
                  state_in = status.crc_match ? ST_EMIT : ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            cmd.load_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (status.emit_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_EMIT;
               end
            end
         end
         default: begin
            state_in     = ST_HUNT;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_SAME(a_no_input_while_emitting, clock, reset, rsp_valid_ff, req_stall, "input open while an item is shown")
   `ASSERT_NEXT(a_hunt_after_last, clock, reset, rsp_acc && status.emit_last, !req_stall && !rsp_valid_ff, "no return to hunting after the final byte")
   `ASSERT_NEXT(a_drop_on_bad_crc, clock, reset, cmd.collect && status.cnt_last && !status.crc_match, !req_stall && !rsp_valid_ff, "packet with bad checksum not dropped")

endmodule

[rtl/cpd_datapath.sv]
// Datapath of the packet deframer: config registers, packet store, CRC and counters.
// Depends on cpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpd_datapath
   import cpd_pkg::*;
#(
   parameter int PACKET_BYTES = 32
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [DATA_W-1:0]     req_data_byte,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [DATA_W-1:0]     rsp_packet_byte,
   output logic [POS_W-1:0]      rsp_byte_position,
   output logic                  rsp_last
);

   localparam int AW = $clog2(PACKET_BYTES);
   localparam logic [AW-1:0] LAST_POS = AW'(PACKET_BYTES - 1);
   localparam logic [AW-1:0] CHK_POS  = AW'(PACKET_BYTES - 2);

   logic [DATA_W-1:0] mem [PACKET_BYTES];

   logic [DATA_W-1:0] header_ff, header_in;
   logic [CRC_W-1:0]  seed_ff, seed_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [DATA_W-1:0] chk_lo_ff, chk_lo_in;
   logic [AW-1:0]     rd_ff, rd_in;
   logic [DATA_W-1:0] out_byte_ff;
   logic [AW-1:0]     out_pos_ff;
   logic              out_last_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   assign status.hdr_match = (req_data_byte == header_ff);
   assign status.cnt_last  = (cnt_ff == LAST_POS);
   assign status.crc_match = ({req_data_byte, chk_lo_ff} == crc_ff);
   assign status.emit_last = out_last_ff;

   assign wr_en   = cmd.start || cmd.collect;
   assign wr_addr = cmd.start ? '0 : cnt_ff;

   always_comb begin
      header_in = header_ff;
      seed_in   = seed_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HEADER: header_in = csr_wdata[DATA_W-1:0];
            CSR_SEED:   seed_in   = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      crc_in    = crc_ff;
      chk_lo_in = chk_lo_ff;
      rd_in     = rd_ff;
      if (cmd.start) begin
         cnt_in = AW'(1);
         crc_in = crc16_update(seed_ff, req_data_byte);
         rd_in  = '0;
      end else if (cmd.collect) begin
         cnt_in = (cnt_ff == LAST_POS) ? '0 : cnt_ff + AW'(1);
         if (cnt_ff < CHK_POS) begin
            crc_in = crc16_update(crc_ff, req_data_byte);
         end
         if (cnt_ff == CHK_POS) begin
            chk_lo_in = req_data_byte;
         end
      end
      if (cmd.advance) begin
         rd_in = rd_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= 8'hA5;
         seed_ff   <= 16'hFFFF;
         cnt_ff    <= '0;
         crc_ff    <= 16'hFFFF;
         rd_ff     <= '0;
      end else begin
         header_ff <= header_in;
         seed_ff   <= seed_in;
         cnt_ff    <= cnt_in;
         crc_ff    <= crc_in;
         rd_ff     <= rd_in;
      end
      chk_lo_ff <= chk_lo_in;
   end

   // Packet store: one write port for collection, one registered read port
   // that feeds the output register directly.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_data_byte;
      end
      if (cmd.load_out) begin
         out_byte_ff <= mem[rd_ff];
         out_pos_ff  <= rd_ff;
         out_last_ff <= (rd_ff == LAST_POS);
      end
   end

   assign rsp_packet_byte   = out_byte_ff;
   assign rsp_byte_position = POS_W'(out_pos_ff);
   assign rsp_last          = out_last_ff;

   `ASSERT_NEXT(a_count_after_header, clock, reset, cmd.start, cnt_ff == AW'(1), "byte count not one after header")
   `ASSERT_NEXT(a_count_wraps, clock, reset, cmd.collect && (cnt_ff == LAST_POS), cnt_ff == '0, "byte count not cleared at packet end")
   `ASSERT_NEXT(a_pos_follows_read, clock, reset, cmd.load_out, out_pos_ff == $past(rd_ff), "output position differs from read address")

endmodule

[rtl/crc16_checked_packet_deframer.sv]
// Top level of the CRC-16 checked packet deframer.
// Depends on cpd_pkg, cpd_ctrl and cpd_datapath.

// The deframer watches a byte stream and hunts for the configured header
// byte; every other byte seen while hunting is dropped. Once a header arrives
// it stores PACKET_BYTES bytes, header included, and runs a reflected CRC-16
// (polynomial 0x8408) seeded from the seed register over all but the last two
// bytes. Those two bytes are the checksum, low byte first. A packet whose
// checksum matches is sent out as PACKET_BYTES items, header first, each with
// its position and a last flag on the final byte; a packet that fails is
// dropped silently and hunting resumes with the next byte. Input bytes are
// taken one per cycle while hunting and collecting. During emission the input
// is stalled; each output item is first read from the packet store into the
// output register and then handed over, held while the receiver stalls, and
// the next item is read only after the receiver takes it. The seed register
// value is sampled when a header is accepted. The configuration port is always
// ready; writes to unknown register indexes are ignored. No clearing pass is
// needed after reset.
module crc16_checked_packet_deframer
   import cpd_pkg::*;
#(
   parameter int PACKET_BYTES = 32
)(
   input  logic                  clock,
   input  logic                  reset,
   // Input byte stream.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_data_byte,
   // Verified packet bytes.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_packet_byte,
   output logic [POS_W-1:0]      rsp_byte_position,
   output logic                  rsp_last,
   // Configuration writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Registers are plain flops, so a write can land in any cycle.
   assign csr_ready = 1'b1;

   cpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpd_datapath #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_byte     (req_data_byte),
      .cmd               (cmd),
      .status            (status),
      .rsp_packet_byte   (rsp_packet_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last          (rsp_last)
   );

endmodule
